// File: src/pccb_pkg.sv
// Shared types, codes and tables of the pixel color count and blend block.
// No dependencies; every other file but pccb_ram refers to it by scoped names.
package pccb_pkg;

  localparam int NUM_COLORS  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 18;

  // input operation codes
  localparam logic [1:0] OP_PLOT       = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLEND_WEIGHT = 2'd2;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_PLOT       = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_READ_CLEAR = 2'd2;
  localparam logic [1:0] CMD_BLACK      = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] color;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t palette(input logic [2:0] c);
    rgb_t p;
    unique case (c)
      3'd0: p = '{8'd128, 8'd255, 8'd255};
      3'd1: p = '{8'd255, 8'd255, 8'd0};
      3'd2: p = '{8'd255, 8'd0,   8'd0};
      3'd3: p = '{8'd255, 8'd128, 8'd0};
      3'd4: p = '{8'd0,   8'd255, 8'd0};
      3'd5: p = '{8'd0,   8'd255, 8'd255};
      3'd6: p = '{8'd255, 8'd128, 8'd255};
      default: p = '{8'd0, 8'd0, 8'd255};
    endcase
    return p;
  endfunction

  // blend order of the palette: colors 2, 3, 4, 1, 7, 6, 5, 0
  function automatic logic [2:0] blend_color(input logic [2:0] step);
    logic [2:0] c;
    unique case (step)
      3'd0: c = 3'd2;
      3'd1: c = 3'd3;
      3'd2: c = 3'd4;
      3'd3: c = 3'd1;
      3'd4: c = 3'd7;
      3'd5: c = 3'd6;
      3'd6: c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // ceil(2^RECIP_SHIFT / m); exact quotient for numerators below 4096
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] m);
    logic [RECIP_W-1:0] r;
    unique case (m)
      4'd2:  r = 18'd65536;
      4'd3:  r = 18'd43691;
      4'd4:  r = 18'd32768;
      4'd5:  r = 18'd26215;
      4'd6:  r = 18'd21846;
      4'd7:  r = 18'd18725;
      4'd8:  r = 18'd16384;
      4'd9:  r = 18'd14564;
      4'd10: r = 18'd13108;
      4'd11: r = 18'd11916;
      4'd12: r = 18'd10923;
      4'd13: r = 18'd10083;
      4'd14: r = 18'd9363;
      4'd15: r = 18'd8739;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

// File: src/pixel_color_count_blend.sv
// Pixel color hit counter with blended readout, top level.
// Holds the configuration registers; depends on pccb_pkg, pccb_front,
// pccb_cmd_fifo and pccb_back.
//
// Usage: items enter through push/full (taken when push is high and full low):
// plot increments one saturating counter of a pixel, read returns the pixel's
// blended RGB, read-and-clear also zeroes the pixel. Out-of-frame plots and
// operation 3 are dropped; out-of-frame reads return black.
// Results leave through empty/pop; the oldest result is on red/green/blue
// while empty is low and is taken when pop is high.
// Configuration: cfg_valid/cfg_ready write frame_width (0), frame_height (1)
// and blend_weight (2); cfg_ready is always high. Write only while idle.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words of the
// counter store, one word per cycle; full stays high meanwhile.
// A four-entry command queue parts the front from the back end. The back end
// handles a plot as a store read, then a write. A read runs through store
// read, blend start, blending (for each color a weighted sum, then a reciprocal
// multiply), blend done and result load into the output registers. While a
// result waits in the result register the back end keeps running plots and
// stalls only on the next result.
module pixel_color_count_blend #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COUNT_BITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] x_coord,
  input  logic [7:0] y_coord,
  input  logic [2:0] color_index,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0]          frame_width;
  logic [8:0]          frame_height;
  logic [3:0]          blend_weight;
  logic                queue_full;
  logic                clearing;
  logic                cmd_push;
  pccb_pkg::cmd_t      cmd;
  pccb_pkg::cmd_head_t head;
  logic                head_pop;

  assign cfg_ready = 1'b1;
  assign full      = queue_full || clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      blend_weight <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pccb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        pccb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        pccb_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  pccb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .push         (push),
    .full         (full),
    .operation    (operation),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .color_index  (color_index),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  pccb_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (queue_full),
    .pop      (head_pop),
    .head     (head)
  );

  pccb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_pop     (head_pop),
    .blend_weight (blend_weight),
    .clearing     (clearing),
    .pop          (pop),
    .empty        (empty),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

endmodule

// File: src/pccb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pccb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/pccb_front.sv
// Front end: frame check and classification of incoming items into commands.
// Depends on pccb_pkg.
module pccb_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic            push,
  input  logic            full,
  input  logic [1:0]      operation,
  input  logic [7:0]      x_coord,
  input  logic [7:0]      y_coord,
  input  logic [2:0]      color_index,
  input  logic [8:0]      frame_width,
  input  logic [8:0]      frame_height,
  output logic            cmd_push,
  output pccb_pkg::cmd_t  cmd
);

  logic in_frame;
  logic keep;

  assign in_frame = (32'(x_coord) < 32'(frame_width))  && (32'(x_coord) < 32'(MAX_WIDTH)) &&
                    (32'(y_coord) < 32'(frame_height)) && (32'(y_coord) < 32'(MAX_HEIGHT));

  always_comb begin
    cmd.x     = x_coord;
    cmd.y     = y_coord;
    cmd.color = color_index;
    cmd.kind  = pccb_pkg::CMD_BLACK;
    keep      = 1'b0;
    unique case (operation)
      pccb_pkg::OP_PLOT: begin
        cmd.kind = pccb_pkg::CMD_PLOT;
        keep     = in_frame;
      end
      pccb_pkg::OP_READ: begin
        cmd.kind = in_frame ? pccb_pkg::CMD_READ : pccb_pkg::CMD_BLACK;
        keep     = 1'b1;
      end
      pccb_pkg::OP_READ_CLEAR: begin
        cmd.kind = in_frame ? pccb_pkg::CMD_READ_CLEAR : pccb_pkg::CMD_BLACK;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    cmd_push = push && !full && keep;
  end

endmodule

// File: src/pccb_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on pccb_pkg.
module pccb_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pccb_pkg::cmd_t       push_cmd,
  output logic                 full,
  input  logic                 pop,
  output pccb_pkg::cmd_head_t  head
);

  pccb_pkg::cmd_t                entries [pccb_pkg::QUEUE_DEPTH];
  logic [pccb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pccb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pccb_pkg::QPTR_W:0]     count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == (pccb_pkg::QPTR_W + 1)'(pccb_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/pccb_blend.sv
// Blend sequencer: walks the eight colors in blend order; for each color a
// weighted sum, then a reciprocal multiply. Depends on pccb_pkg.
module pccb_blend #(
  parameter int COUNT_BITS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [pccb_pkg::NUM_COLORS*COUNT_BITS-1:0] counts,
  input  logic [3:0]                               mix,
  output logic                                     done,
  output pccb_pkg::rgb_t                           result
);

  localparam int CMP_W  = (COUNT_BITS > 4) ? COUNT_BITS : 4;
  localparam int PROD_W = 12 + pccb_pkg::RECIP_W;

  logic [pccb_pkg::NUM_COLORS*COUNT_BITS-1:0] cnt_q;
  logic                                       busy;
  logic                                       phase;
  logic [2:0]                                 step;
  logic                                       skip;
  logic [7:0]                                 bg [3];
  logic [11:0]                                sum [3];

  logic [2:0]                 color;
  logic [COUNT_BITS-1:0]      cnt;
  logic [3:0]                 k;
  pccb_pkg::rgb_t             pal;
  logic [7:0]                 pal_ch [3];
  logic [pccb_pkg::RECIP_W-1:0] rcp;
  logic [PROD_W-1:0]          prod [3];
  logic [12:0]                quo [3];

  always_comb begin
    color     = pccb_pkg::blend_color(step);
    cnt       = cnt_q[32'(color) * COUNT_BITS +: COUNT_BITS];
    k         = (CMP_W'(cnt) > CMP_W'(mix)) ? mix : 4'(cnt);
    pal       = pccb_pkg::palette(color);
    pal_ch[0] = pal.red;
    pal_ch[1] = pal.green;
    pal_ch[2] = pal.blue;
    rcp       = pccb_pkg::recip(mix);
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(sum[ch]) * PROD_W'(rcp);
      quo[ch]  = 13'(prod[ch] >> pccb_pkg::RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_q <= counts;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (start) begin
        bg[ch] <= '0;
      end else if (busy && !phase) begin
        sum[ch] <= 12'(12'(pal_ch[ch]) * 12'(k) + 12'(bg[ch]) * 12'(mix - k));
      end else if (busy && phase && !skip) begin
        bg[ch] <= (quo[ch] > 13'd255) ? 8'd255 : quo[ch][7:0];
      end
    end
    if (busy && !phase) begin
      skip <= (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && phase && (step == 3'd7);
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        step  <= '0;
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          step <= step + 1'b1;
          if (step == 3'd7) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  assign result.red   = bg[0];
  assign result.green = bg[1];
  assign result.blue  = bg[2];

endmodule

// File: src/pccb_back.sv
// Back end: clearing pass, counter store read-modify-write, blend control and
// the result register. Depends on pccb_pkg, pccb_ram and pccb_blend.
module pccb_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COUNT_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  pccb_pkg::cmd_head_t head,
  output logic                head_pop,
  input  logic [3:0]          blend_weight,
  output logic                clearing,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = pccb_pkg::NUM_COLORS * COUNT_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_BLEND = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [1:0]        cur_kind;
  logic [2:0]        cur_color;
  pccb_pkg::rgb_t    res;
  logic              out_valid;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [WORD_W-1:0] rdata;
  logic [31:0]       head_addr_full;
  logic [ADDR_W-1:0] head_addr;
  logic [WORD_W-1:0] inc_word;
  logic [COUNT_BITS-1:0] lane;
  logic              blend_start;
  logic              blend_done;
  pccb_pkg::rgb_t    blend_res;
  logic [3:0]        mix;
  logic              load_out;

  assign mix            = (blend_weight == 4'd0) ? 4'd1 : blend_weight;
  assign head_addr_full = 32'(head.cmd.y) * 32'(MAX_WIDTH) + 32'(head.cmd.x);
  assign head_addr      = head_addr_full[ADDR_W-1:0];
  assign clearing       = (state == ST_CLEAR);
  assign empty          = !out_valid;
  assign load_out       = (state == ST_EMIT) && (!out_valid || pop);

  // saturating increment of the plotted color's counter
  always_comb begin
    inc_word = rdata;
    for (int i = 0; i < pccb_pkg::NUM_COLORS; i++) begin
      lane = rdata[i*COUNT_BITS +: COUNT_BITS];
      if ((3'(i) == cur_color) && (lane != '1)) begin
        lane = lane + COUNT_BITS'(1);
      end
      inc_word[i*COUNT_BITS +: COUNT_BITS] = lane;
    end
  end

  always_comb begin
    state_next  = state;
    head_pop    = 1'b0;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = '0;
    re          = 1'b0;
    blend_start = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (head.valid) begin
          head_pop = 1'b1;
          if (head.cmd.kind == pccb_pkg::CMD_BLACK) begin
            state_next = ST_EMIT;
          end else begin
            re         = 1'b1;
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (cur_kind == pccb_pkg::CMD_PLOT) begin
          we         = 1'b1;
          wdata      = inc_word;
          state_next = ST_ISSUE;
        end else begin
          blend_start = 1'b1;
          we          = (cur_kind == pccb_pkg::CMD_READ_CLEAR);
          state_next  = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (blend_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_next = ST_ISSUE;
        end
      end
      default: state_next = ST_ISSUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur_addr  <= head_addr;
      cur_kind  <= head.cmd.kind;
      cur_color <= head.cmd.color;
      res       <= '0;
    end else if ((state == ST_BLEND) && blend_done) begin
      res <= blend_res;
    end
    if (load_out) begin
      red   <= res.red;
      green <= res.green;
      blue  <= res.blue;
    end
  end

  pccb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (head_addr),
    .rdata (rdata)
  );

  pccb_blend #(
    .COUNT_BITS(COUNT_BITS)
  ) u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (blend_start),
    .counts (rdata),
    .mix    (mix),
    .done   (blend_done),
    .result (blend_res)
  );

endmodule
